// ===== rtl/core/flp_pkg.sv =====
// Package for the fetch response literal parser: parser states, status codes,
// protocol characters and the default length-counter width. No dependencies.
package flp_pkg;

  localparam int unsigned LEN_BITS_DEF = 32;

  typedef enum logic [3:0] {
    ST_LINE    = 4'd0,
    ST_SPACE1  = 4'd1,
    ST_TOKEN   = 4'd2,
    ST_BRACE   = 4'd3,
    ST_DIGITS  = 4'd4,
    ST_HDR_CR  = 4'd5,
    ST_HDR_LF  = 4'd6,
    ST_DATA    = 4'd7,
    ST_TAIL_CR = 4'd8,
    ST_TAIL_LF = 4'd9,
    ST_SKIP    = 4'd10,
    ST_SKIP_LF = 4'd11,
    ST_END_CR  = 4'd12,
    ST_END_LF  = 4'd13
  } parse_state_t;

  typedef enum logic [3:0] {
    STS_PROGRESS    = 4'd0,
    STS_PAYLOAD     = 4'd1,
    STS_DONE        = 4'd2,
    STS_ERR_HDR_CR  = 4'd3,
    STS_ERR_HDR_LF  = 4'd4,
    STS_ERR_TAIL_CR = 4'd5,
    STS_ERR_TAIL_LF = 4'd6,
    STS_ERR_SKIP_LF = 4'd7,
    STS_ERR_END_CR  = 4'd8,
    STS_ERR_END_LF  = 4'd9
  } status_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

// ===== rtl/core/flp_if.sv =====
// Valid/ready channel interfaces for the parser: input byte words and result words.
// Depends on nothing.
interface flp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface flp_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic [7:0] payload;

  modport source (output valid, output status, output payload, input ready);
  modport sink (input valid, input status, input payload, output ready);
endinterface

// ===== rtl/core/flp_step.sv =====
// Next-state logic of the parser for one byte: state transitions, length
// accumulation with saturation, payload count-down. Depends on flp_pkg.
module flp_step #(
  parameter int unsigned LEN_BITS = flp_pkg::LEN_BITS_DEF
) (
  input  flp_pkg::parse_state_t state,
  input  logic [LEN_BITS-1:0]   count,
  input  logic                  stopped,
  input  logic [7:0]            byte_in,
  output flp_pkg::parse_state_t state_next,
  output logic [LEN_BITS-1:0]   count_next,
  output logic                  stopped_next,
  output flp_pkg::status_t      status,
  output logic [7:0]            payload
);

  localparam int unsigned W = LEN_BITS + 4;

  logic                  is_digit;
  logic [W-1:0]          times10;
  logic [LEN_BITS-1:0]   acc_sat;
  flp_pkg::parse_state_t skip_state;

  assign is_digit = (byte_in >= flp_pkg::CH_ZERO) && (byte_in <= flp_pkg::CH_NINE);
  assign times10  = (W'(count) << 3) + (W'(count) << 1)
                  + W'(4'(byte_in - flp_pkg::CH_ZERO));
  assign acc_sat  = (times10[W-1:LEN_BITS] != '0) ? '1 : times10[LEN_BITS-1:0];

  always_comb begin
    if (byte_in == flp_pkg::CH_CR) begin
      skip_state = flp_pkg::ST_SKIP_LF;
    end else if (byte_in == flp_pkg::CH_AT) begin
      skip_state = flp_pkg::ST_END_CR;
    end else begin
      skip_state = flp_pkg::ST_SKIP;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    stopped_next = stopped;
    status       = flp_pkg::STS_PROGRESS;
    payload      = '0;
    if (state == flp_pkg::ST_DATA) begin
      status  = flp_pkg::STS_PAYLOAD;
      payload = byte_in;
      if (count != '0) begin
        count_next = count - LEN_BITS'(1);
      end
      if (count <= LEN_BITS'(1)) begin
        state_next = flp_pkg::ST_TAIL_CR;
      end
    end else if (byte_in != flp_pkg::CH_NUL) begin
      case (state)
        flp_pkg::ST_SPACE1: begin
          state_next = (byte_in == flp_pkg::CH_SPACE) ? flp_pkg::ST_TOKEN : skip_state;
        end
        flp_pkg::ST_TOKEN: begin
          if (byte_in == flp_pkg::CH_SPACE) begin
            state_next = flp_pkg::ST_BRACE;
          end
        end
        flp_pkg::ST_BRACE: begin
          if (byte_in == flp_pkg::CH_LBRACE) begin
            count_next   = '0;
            stopped_next = 1'b0;
            state_next   = flp_pkg::ST_DIGITS;
          end else begin
            state_next = skip_state;
          end
        end
        flp_pkg::ST_DIGITS: begin
          if (byte_in == flp_pkg::CH_RBRACE) begin
            state_next = flp_pkg::ST_HDR_CR;
          end else if (!stopped && is_digit) begin
            count_next = acc_sat;
          end else begin
            stopped_next = 1'b1;
          end
        end
        flp_pkg::ST_HDR_CR: begin
          if (byte_in == flp_pkg::CH_CR) begin
            state_next = flp_pkg::ST_HDR_LF;
          end else begin
            status = flp_pkg::STS_ERR_HDR_CR;
          end
        end
        flp_pkg::ST_HDR_LF: begin
          if (byte_in == flp_pkg::CH_LF) begin
            stopped_next = 1'b0;
            state_next   = (count != '0) ? flp_pkg::ST_DATA : flp_pkg::ST_TAIL_CR;
          end else begin
            status = flp_pkg::STS_ERR_HDR_LF;
          end
        end
        flp_pkg::ST_TAIL_CR: begin
          if (byte_in == flp_pkg::CH_CR) begin
            state_next = flp_pkg::ST_TAIL_LF;
          end else begin
            status = flp_pkg::STS_ERR_TAIL_CR;
          end
        end
        flp_pkg::ST_TAIL_LF: begin
          if (byte_in == flp_pkg::CH_LF) begin
            state_next = flp_pkg::ST_LINE;
          end else begin
            status = flp_pkg::STS_ERR_TAIL_LF;
          end
        end
        flp_pkg::ST_SKIP: begin
          state_next = skip_state;
        end
        flp_pkg::ST_SKIP_LF: begin
          if (byte_in == flp_pkg::CH_LF) begin
            state_next = flp_pkg::ST_LINE;
          end else begin
            status = flp_pkg::STS_ERR_SKIP_LF;
          end
        end
        flp_pkg::ST_END_CR: begin
          if (byte_in == flp_pkg::CH_CR) begin
            state_next = flp_pkg::ST_END_LF;
          end else begin
            status = flp_pkg::STS_ERR_END_CR;
          end
        end
        flp_pkg::ST_END_LF: begin
          if (byte_in == flp_pkg::CH_LF) begin
            state_next = flp_pkg::ST_LINE;
            status     = flp_pkg::STS_DONE;
          end else begin
            status = flp_pkg::STS_ERR_END_LF;
          end
        end
        default: begin
          // line start, and any code outside the state list
          state_next = (byte_in == flp_pkg::CH_STAR) ? flp_pkg::ST_SPACE1 : skip_state;
        end
      endcase
      // Leaving for line start (done, error, end of line) drops the length
      if (state_next == flp_pkg::ST_LINE || status != flp_pkg::STS_PROGRESS) begin
        state_next   = flp_pkg::ST_LINE;
        count_next   = '0;
        stopped_next = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/fetch_response_literal_parser.sv =====
// Top level of the fetch response literal parser: input register, parse state,
// result register. Depends on flp_pkg, flp_if.sv and flp_step.
//
//   channel    dir  word      fields
//   byte_ch    in   1 byte    byte_in[7:0]
//   result_ch  out  1 result  status[3:0], payload[7:0]
//
// One result word per byte word; one byte per cycle sustained while result_ch
// is ready. A byte is registered at acceptance and parsed against the parse
// state; its result is registered together with the state update, as the byte
// leaves the input register. rst clears valid flags and the parse state (line
// start, zero length). A stalled result holds the result register; the input
// register and then byte_ch.ready back up behind it.
module fetch_response_literal_parser #(
  parameter int unsigned LEN_BITS = flp_pkg::LEN_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  flp_byte_if.sink           byte_ch,
  flp_result_if.source       result_ch
);

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;

  // Parse state
  flp_pkg::parse_state_t state;
  flp_pkg::parse_state_t state_next;
  logic [LEN_BITS-1:0]   count;
  logic [LEN_BITS-1:0]   count_next;
  logic                  stopped;
  logic                  stopped_next;

  // Result register
  logic             res_valid;
  flp_pkg::status_t res_status;
  logic [7:0]       res_payload;
  flp_pkg::status_t step_status;
  logic [7:0]       step_payload;

  logic advance;

  // Advance the input word when the result register is free or draining
  assign advance       = in_valid && (!res_valid || result_ch.ready);
  assign byte_ch.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_ch.ready) begin
      in_valid <= byte_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      in_byte <= byte_ch.byte_in;
    end
  end

  flp_step #(
    .LEN_BITS (LEN_BITS)
  ) u_step (
    .state        (state),
    .count        (count),
    .stopped      (stopped),
    .byte_in      (in_byte),
    .state_next   (state_next),
    .count_next   (count_next),
    .stopped_next (stopped_next),
    .status       (step_status),
    .payload      (step_payload)
  );

  // Update parse state only as a word moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= flp_pkg::ST_LINE;
      count   <= '0;
      stopped <= 1'b0;
    end else if (advance) begin
      state   <= state_next;
      count   <= count_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_status  <= step_status;
      res_payload <= step_payload;
    end
  end

  assign result_ch.valid   = res_valid;
  assign result_ch.status  = res_status;
  assign result_ch.payload = res_payload;

endmodule
